### sv/lev_pkg.sv
// Shared types for the edit distance cell chain.
`timescale 1ns / 1ps
`default_nettype none

package lev_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_REF   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_FIN   = 2'd2;

	// Token kinds that travel along the cell chain.
	typedef enum logic [1:0] {
		TOK_NOP,
		TOK_REF,
		TOK_QUERY,
		TOK_FIN
	} tok_kind_t;

	// Control part of a token; the score fields travel beside it.
	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] sym;
		logic       ovf;
	} tok_ctl_t;

endpackage : lev_pkg

`default_nettype wire

### sv/lev_cell.sv
// One column cell of the edit distance chain: a reference byte and its score.
`timescale 1ns / 1ps
`default_nettype none

module lev_cell #(
	parameter int VW    = 7,
	parameter int INDEX = 1
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     adv,
	input  wire lev_pkg::tok_ctl_t  ctl_in,
	input  wire  [VW-1:0]           vnew_in,
	input  wire  [VW-1:0]           vold_in,
	output lev_pkg::tok_ctl_t       ctl_out,
	output logic [VW-1:0]           vnew_out,
	output logic [VW-1:0]           vold_out
);
	import lev_pkg::*;

	localparam logic [VW-1:0] RST_VAL = VW'(INDEX);

	logic          vld_q;
	logic [7:0]    sym_q;
	logic [VW-1:0] val_q;
	tok_ctl_t      ctl_q;
	logic [VW-1:0] vnew_q;
	logic [VW-1:0] vold_q;

	logic [VW:0]   up_sum;
	logic [VW:0]   left_sum;
	logic [VW:0]   diag_sum;
	logic [VW:0]   min_ul;
	logic [VW:0]   min_all;

	// Unit-cost recurrence: above + 1, left + 1, diagonal + mismatch.
	always_comb begin
		up_sum   = {1'b0, val_q} + (VW+1)'(1);
		left_sum = {1'b0, vnew_in} + (VW+1)'(1);
		diag_sum = {1'b0, vold_in} + (VW+1)'(sym_q != ctl_in.sym);
		min_ul   = (up_sum < left_sum) ? up_sum : left_sum;
		min_all  = (min_ul < diag_sum) ? min_ul : diag_sum;
	end

	// Cell state: a reference byte is claimed by the first empty cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			val_q <= RST_VAL;
		end else if (adv) begin
			unique case (ctl_in.kind)
				TOK_REF: begin
					if (!vld_q) begin
						vld_q <= 1'b1;
					end
				end
				TOK_QUERY: begin
					if (vld_q) begin
						val_q <= min_all[VW-1:0];
					end
				end
				TOK_FIN: begin
					vld_q <= 1'b0;
					val_q <= RST_VAL;
				end
				default: begin
				end
			endcase
		end
	end

	// Reference byte storage.
	always_ff @(posedge clk) begin
		if (adv && ctl_in.kind == TOK_REF && !vld_q) begin
			sym_q <= ctl_in.sym;
		end
	end

	// Token register toward the right neighbor; a claimed reference byte leaves a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.kind <= TOK_NOP;
			ctl_q.sym  <= '0;
			ctl_q.ovf  <= 1'b0;
		end else if (adv) begin
			ctl_q.sym <= ctl_in.sym;
			ctl_q.ovf <= ctl_in.ovf;
			if (ctl_in.kind == TOK_REF && !vld_q) begin
				ctl_q.kind <= TOK_NOP;
			end else begin
				ctl_q.kind <= ctl_in.kind;
			end
		end
	end

	// Token payload: new and old score of this column, or the running distance.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctl_in.kind == TOK_QUERY) begin
				vnew_q <= vld_q ? min_all[VW-1:0] : vnew_in;
				vold_q <= val_q;
			end else if (ctl_in.kind == TOK_FIN) begin
				vnew_q <= vld_q ? val_q : vnew_in;
				vold_q <= vold_in;
			end else begin
				vnew_q <= vnew_in;
				vold_q <= vold_in;
			end
		end
	end

	assign ctl_out  = ctl_q;
	assign vnew_out = vnew_q;
	assign vold_out = vold_q;

endmodule : lev_cell

`default_nettype wire

### sv/levenshtein_distance_unit.sv
// Top level of the edit distance unit: beat intake, cell chain and result register.
//
//  channel | direction | beat contents         | handshake
//  --------+-----------+-----------------------+----------------------
//  in      | into unit | operation, symbol     | in_valid / in_ready
//  out     | from unit | distance, overflow    | out_valid / out_ready
//
// One input beat is taken every cycle while the chain advances; each beat becomes
// a token that walks the chain of MAX_LEN cells one cell per cycle, so query rows
// overlap as a wavefront. A finish token at the tail raises out_valid.
// Reset loads every cell score with its column index and empties the reference.
// The chain stalls only while a finish token sits at the tail and the result
// register still holds a beat that has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module levenshtein_distance_unit #(
	parameter int MAX_LEN = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] operation,
	input  wire  [7:0] symbol,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [6:0] distance,
	output logic       overflow
);
	import lev_pkg::*;

	localparam int VW = $clog2(MAX_LEN + 1);
	localparam int OW = (VW > 7) ? VW : 7;
	localparam logic [VW-1:0] MAX_CNT = VW'(MAX_LEN);

	logic [VW-1:0] ref_len_q;
	logic [VW-1:0] qry_len_q;
	logic          ovf_q;
	logic          adv;
	logic          take;

	tok_ctl_t      head_ctl;
	logic [VW-1:0] head_vnew;
	logic [VW-1:0] head_vold;

	tok_ctl_t      ctl_c  [MAX_LEN+1];
	logic [VW-1:0] vnew_c [MAX_LEN+1];
	logic [VW-1:0] vold_c [MAX_LEN+1];

	logic          out_valid_q;
	logic [6:0]    distance_q;
	logic          overflow_q;
	logic [OW-1:0] dist_ext;

	// The chain moves unless a finish token is blocked at the tail.
	assign adv      = !(out_valid_q && !out_ready && ctl_c[MAX_LEN].kind == TOK_FIN);
	assign in_ready = adv;
	assign take     = in_valid && adv;

	// Turn the accepted beat into a token; refused symbols become bubbles.
	always_comb begin
		head_ctl.kind = TOK_NOP;
		head_ctl.sym  = symbol;
		head_ctl.ovf  = ovf_q;
		head_vnew     = qry_len_q;
		head_vold     = qry_len_q;
		if (take) begin
			unique case (operation)
				OP_REF: begin
					if (qry_len_q == '0 && ref_len_q < MAX_CNT) begin
						head_ctl.kind = TOK_REF;
					end
				end
				OP_QUERY: begin
					if (qry_len_q < MAX_CNT) begin
						head_ctl.kind = TOK_QUERY;
						head_vnew     = qry_len_q + VW'(1);
					end
				end
				OP_FIN: begin
					head_ctl.kind = TOK_FIN;
				end
				default: begin
				end
			endcase
		end
	end

	assign ctl_c[0]  = head_ctl;
	assign vnew_c[0] = head_vnew;
	assign vold_c[0] = head_vold;

	// String lengths and the truncation flag for the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q <= '0;
			qry_len_q <= '0;
			ovf_q     <= 1'b0;
		end else if (take) begin
			unique case (operation)
				OP_REF: begin
					if (qry_len_q != '0 || ref_len_q >= MAX_CNT) begin
						ovf_q <= 1'b1;
					end else begin
						ref_len_q <= ref_len_q + VW'(1);
					end
				end
				OP_QUERY: begin
					if (qry_len_q >= MAX_CNT) begin
						ovf_q <= 1'b1;
					end else begin
						qry_len_q <= qry_len_q + VW'(1);
					end
				end
				OP_FIN: begin
					ref_len_q <= '0;
					qry_len_q <= '0;
					ovf_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Row of column cells.
	for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
		lev_cell #(
			.VW    (VW),
			.INDEX (gi + 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl_c[gi]),
			.vnew_in  (vnew_c[gi]),
			.vold_in  (vold_c[gi]),
			.ctl_out  (ctl_c[gi+1]),
			.vnew_out (vnew_c[gi+1]),
			.vold_out (vold_c[gi+1])
		);
	end

	// Saturate the distance to the 7-bit field.
	assign dist_ext = OW'(vnew_c[MAX_LEN]);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && ctl_c[MAX_LEN].kind == TOK_FIN) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_c[MAX_LEN].kind == TOK_FIN) begin
			distance_q <= (dist_ext > OW'(127)) ? 7'd127 : dist_ext[6:0];
			overflow_q <= ctl_c[MAX_LEN].ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign overflow  = overflow_q;

endmodule : levenshtein_distance_unit

`default_nettype wire
